// ----- hw/rtl/adrc_pkg.sv -----
// ----------------------------------------------------------------------------
// adrc_pkg
// Shared types, constants and knob lookup tables of the dynamic range
// compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package adrc_pkg;

  localparam int KNOB_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 2'd2;

  localparam logic [KNOB_W-1:0] KNOB_MAX = 7'd100;

  localparam logic [18:0] ATTACK_Q24  = 19'd335544;
  localparam logic [18:0] RELEASE_Q24 = 19'd25166;
  localparam logic [24:0] ONE_Q24     = 25'h1000000;
  localparam logic [23:0] ENV_MAX     = 24'hFFFFFF;

  localparam logic [7:0] RATIO_DEN_BASE  = 8'd50;
  localparam logic [7:0] RATIO_HALF_BASE = 8'd25;
  localparam logic [4:0] EXCESS_SCALE    = 5'd25;

  localparam logic [4:0] DIV1_STEPS = 5'd24;
  localparam logic [4:0] DIV2_STEPS = 5'd25;

  typedef logic [23:0] knob_lut_t [0:100];

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV_MUL,
    S_ENV_UPD,
    S_THR_CHK,
    S_EXC_MUL,
    S_DIV1_LOAD,
    S_DIV1,
    S_DIV2_LOAD,
    S_DIV2,
    S_TGT,
    S_GAIN_MUL,
    S_GAIN_UPD,
    S_Y1_MUL,
    S_Y1_RND,
    S_Y2_MUL,
    S_OUT
  } adrc_state_t;

  // threshold in q0.24: 0.35 - 0.29 * k / 100
  function automatic knob_lut_t thr_lut_build();
    knob_lut_t lut;
    longint    v;
    for (int k = 0; k <= 100; k++) begin
      v = (longint'(3500 - 29 * k) * 64'sd16777216 + 64'sd5000) / 64'sd10000;
      lut[k] = 24'(v);
    end
    return lut;
  endfunction

  // makeup gain in q2.22: 0.9 + 2.6 * k / 100
  function automatic knob_lut_t makeup_lut_build();
    knob_lut_t lut;
    longint    v;
    for (int k = 0; k <= 100; k++) begin
      v = (longint'(900 + 26 * k) * 64'sd4194304 + 64'sd500) / 64'sd1000;
      lut[k] = 24'(v);
    end
    return lut;
  endfunction

  localparam knob_lut_t THR_LUT    = thr_lut_build();
  localparam knob_lut_t MAKEUP_LUT = makeup_lut_build();

endpackage

`default_nettype wire

// ----- hw/rtl/audio_dynamic_range_compressor_unit.sv -----
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor_unit
// Feed-forward compressor: peak envelope follower, gain computer, smoothed
// gain and makeup gain, with one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// One signed sample in, one saturated compressed sample out. The block
// handles one item at a time: it takes an item, stalls its input while a
// small sequencer drives a shared multiplier and a shared restoring divider,
// and returns to accepting once the result sits in the output register.
// While the envelope is at or below the threshold an item skips the two
// divisions; above it they run (24 and 25 steps of the one-bit-per-cycle
// divider). A waiting result does not block the next item, only the
// delivery of the one after it.
`default_nettype none

module audio_dynamic_range_compressor_unit #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_audio_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_audio_out,
  input  logic                                 cfg_we,
  input  logic [adrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [adrc_pkg::KNOB_W-1:0]          cfg_wdata
);

  localparam int MAW  = (SAMPLE_BITS > 26) ? SAMPLE_BITS : 26;
  localparam int MBW  = 26;
  localparam int PW   = MAW + MBW;
  localparam int LW   = SAMPLE_BITS + 26;
  localparam int LSH  = (SAMPLE_BITS <= 25) ? (25 - SAMPLE_BITS) : 0;
  localparam int RSH  = (SAMPLE_BITS > 25) ? (SAMPLE_BITS - 25) : 1;

  localparam logic [LW-1:0]        LBIAS     = LW'(64'd1 << (RSH - 1));
  localparam logic signed [PW-1:0] RND24     = PW'(64'd1 << 23);
  localparam logic signed [PW-1:0] RND22     = PW'(64'd1 << 21);
  localparam logic signed [PW-1:0] ENV_MAX_P = PW'(adrc_pkg::ENV_MAX);
  localparam logic signed [PW-1:0] ONE_P     = PW'(adrc_pkg::ONE_Q24);
  localparam logic signed [PW-1:0] HI_P      = PW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [PW-1:0] LO_P      = ~HI_P;

  adrc_pkg::adrc_state_t state_r, state_nxt;

  logic [adrc_pkg::KNOB_W-1:0] thr_knob_r, ratio_knob_r, makeup_knob_r;

  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [23:0]                   level_r, level_nxt;
  logic [23:0]                   env_r, env_nxt;
  logic [24:0]                   gain_r, gain_nxt;
  logic [24:0]                   target_r, target_nxt;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic [23:0]                   rem_r, rem_nxt;
  logic [24:0]                   quo_r, quo_nxt;
  logic [23:0]                   dvs_r, dvs_nxt;
  logic [4:0]                    cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  logic [adrc_pkg::KNOB_W-1:0] kt_w, kr_w, km_w;
  logic [23:0]                 thr_w, makeup_w;
  logic [7:0]                  den_w, half_w;
  logic [SAMPLE_BITS-1:0]      mag_w;
  logic [LW-1:0]               lvl_wide_w;
  logic [23:0]                 level_w;
  logic signed [24:0]          env_diff_w;
  logic signed [25:0]          gain_diff_w;
  logic [23:0]                 excess_w;
  logic signed [MAW-1:0]       mul_a_w;
  logic signed [MBW-1:0]       mul_b_w;
  logic signed [PW-1:0]        prod_w;
  logic signed [PW-1:0]        r24_w, r22_w;
  logic signed [PW-1:0]        env_sum_w, gain_sum_w;
  logic [23:0]                 env_clamp_w;
  logic [24:0]                 gain_clamp_w;
  logic signed [SAMPLE_BITS-1:0] sat_w;
  logic [24:0]                 trial_w;
  logic                        ge_w;
  logic [23:0]                 div_rem_w;
  logic [24:0]                 div_quo_w;
  logic [28:0]                 num1_w;
  logic [24:0]                 comp_w;

  // knob registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_knob_r    <= '0;
      ratio_knob_r  <= '0;
      makeup_knob_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        adrc_pkg::CFG_THRESHOLD: thr_knob_r    <= cfg_wdata;
        adrc_pkg::CFG_RATIO:     ratio_knob_r  <= cfg_wdata;
        adrc_pkg::CFG_MAKEUP:    makeup_knob_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign kt_w = (thr_knob_r > adrc_pkg::KNOB_MAX) ? adrc_pkg::KNOB_MAX : thr_knob_r;
  assign kr_w = (ratio_knob_r > adrc_pkg::KNOB_MAX) ? adrc_pkg::KNOB_MAX : ratio_knob_r;
  assign km_w = (makeup_knob_r > adrc_pkg::KNOB_MAX) ? adrc_pkg::KNOB_MAX : makeup_knob_r;

  assign thr_w    = adrc_pkg::THR_LUT[kt_w];
  assign makeup_w = adrc_pkg::MAKEUP_LUT[km_w];
  assign den_w    = adrc_pkg::RATIO_DEN_BASE + {kr_w, 1'b0};
  assign half_w   = adrc_pkg::RATIO_HALF_BASE + 8'(kr_w);

  // input magnitude aligned to q0.24
  assign mag_w      = in_audio_in[SAMPLE_BITS-1] ? (~in_audio_in + 1'b1) : in_audio_in;
  assign lvl_wide_w = (SAMPLE_BITS <= 25) ? (LW'(mag_w) << LSH)
                                          : ((LW'(mag_w) + LBIAS) >> RSH);
  assign level_w    = (lvl_wide_w > LW'(adrc_pkg::ENV_MAX)) ? adrc_pkg::ENV_MAX
                                                            : lvl_wide_w[23:0];

  assign env_diff_w  = $signed({1'b0, level_r}) - $signed({1'b0, env_r});
  assign gain_diff_w = $signed({1'b0, target_r}) - $signed({1'b0, gain_r});
  assign excess_w    = env_r - thr_w;

  // shared multiplier operand select
  always_comb begin
    mul_a_w = '0;
    mul_b_w = '0;
    case (state_r)
      adrc_pkg::S_ENV_MUL: begin
        mul_a_w = MAW'(env_diff_w);
        mul_b_w = (level_r > env_r) ? MBW'(adrc_pkg::ATTACK_Q24)
                                    : MBW'(adrc_pkg::RELEASE_Q24);
      end
      adrc_pkg::S_EXC_MUL: begin
        mul_a_w = MAW'(excess_w);
        mul_b_w = MBW'(adrc_pkg::EXCESS_SCALE);
      end
      adrc_pkg::S_GAIN_MUL: begin
        mul_a_w = MAW'(gain_diff_w);
        mul_b_w = (target_r < gain_r) ? MBW'(adrc_pkg::ATTACK_Q24)
                                      : MBW'(adrc_pkg::RELEASE_Q24);
      end
      adrc_pkg::S_Y1_MUL: begin
        mul_a_w = MAW'(x_r);
        mul_b_w = MBW'(gain_r);
      end
      adrc_pkg::S_Y2_MUL: begin
        mul_a_w = MAW'(x_r);
        mul_b_w = MBW'(makeup_w);
      end
      default: ;
    endcase
  end

  assign prod_w = mul_a_w * mul_b_w;
  assign r24_w  = (prod_r + RND24) >>> 24;
  assign r22_w  = (prod_r + RND22) >>> 22;

  assign env_sum_w   = $signed(PW'({1'b0, env_r})) + r24_w;
  assign env_clamp_w = env_sum_w[PW-1] ? '0 :
                       (env_sum_w > ENV_MAX_P) ? adrc_pkg::ENV_MAX : 24'(env_sum_w);

  assign gain_sum_w   = $signed(PW'({1'b0, gain_r})) + r24_w;
  assign gain_clamp_w = gain_sum_w[PW-1] ? '0 :
                        (gain_sum_w > ONE_P) ? adrc_pkg::ONE_Q24 : 25'(gain_sum_w);

  assign sat_w = (r22_w > HI_P) ? SAMPLE_BITS'(HI_P) :
                 (r22_w < LO_P) ? SAMPLE_BITS'(LO_P) : SAMPLE_BITS'(r22_w);

  // restoring divider, one quotient bit per cycle
  assign trial_w   = {rem_r, quo_r[24]};
  assign ge_w      = trial_w >= {1'b0, dvs_r};
  assign div_rem_w = ge_w ? 24'(trial_w - {1'b0, dvs_r}) : trial_w[23:0];
  assign div_quo_w = {quo_r[23:0], ge_w};

  assign num1_w = 29'(prod_r) + 29'(half_w);
  assign comp_w = 25'(thr_w) + 25'(quo_r[23:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adrc_pkg::S_IDLE;
      env_r       <= '0;
      gain_r      <= adrc_pkg::ONE_Q24;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_r       <= env_nxt;
      gain_r      <= gain_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    level_r    <= level_nxt;
    target_r   <= target_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    level_nxt     = level_r;
    env_nxt       = env_r;
    gain_nxt      = gain_r;
    target_nxt    = target_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      adrc_pkg::S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_audio_in;
          level_nxt = level_w;
          state_nxt = adrc_pkg::S_ENV_MUL;
        end
      end
      adrc_pkg::S_ENV_MUL: begin
        prod_nxt  = prod_w;
        state_nxt = adrc_pkg::S_ENV_UPD;
      end
      adrc_pkg::S_ENV_UPD: begin
        env_nxt   = env_clamp_w;
        state_nxt = adrc_pkg::S_THR_CHK;
      end
      adrc_pkg::S_THR_CHK: begin
        if (env_r > thr_w) begin
          state_nxt = adrc_pkg::S_EXC_MUL;
        end else begin
          target_nxt = adrc_pkg::ONE_Q24;
          state_nxt  = adrc_pkg::S_GAIN_MUL;
        end
      end
      adrc_pkg::S_EXC_MUL: begin
        prod_nxt  = prod_w;
        state_nxt = adrc_pkg::S_DIV1_LOAD;
      end
      adrc_pkg::S_DIV1_LOAD: begin
        // excess / ratio, rounded
        rem_nxt   = 24'(num1_w[28:24]);
        quo_nxt   = {num1_w[23:0], 1'b0};
        dvs_nxt   = 24'(den_w);
        cnt_nxt   = adrc_pkg::DIV1_STEPS;
        state_nxt = adrc_pkg::S_DIV1;
      end
      adrc_pkg::S_DIV1: begin
        rem_nxt = div_rem_w;
        quo_nxt = div_quo_w;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          state_nxt = adrc_pkg::S_DIV2_LOAD;
        end
      end
      adrc_pkg::S_DIV2_LOAD: begin
        // compressed level / envelope, rounded
        rem_nxt   = comp_w[24:1];
        quo_nxt   = {comp_w[0], 1'b0, env_r[23:1]};
        dvs_nxt   = env_r;
        cnt_nxt   = adrc_pkg::DIV2_STEPS;
        state_nxt = adrc_pkg::S_DIV2;
      end
      adrc_pkg::S_DIV2: begin
        rem_nxt = div_rem_w;
        quo_nxt = div_quo_w;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          state_nxt = adrc_pkg::S_TGT;
        end
      end
      adrc_pkg::S_TGT: begin
        target_nxt = (quo_r > adrc_pkg::ONE_Q24) ? adrc_pkg::ONE_Q24 : quo_r;
        state_nxt  = adrc_pkg::S_GAIN_MUL;
      end
      adrc_pkg::S_GAIN_MUL: begin
        prod_nxt  = prod_w;
        state_nxt = adrc_pkg::S_GAIN_UPD;
      end
      adrc_pkg::S_GAIN_UPD: begin
        gain_nxt  = gain_clamp_w;
        state_nxt = adrc_pkg::S_Y1_MUL;
      end
      adrc_pkg::S_Y1_MUL: begin
        prod_nxt  = prod_w;
        state_nxt = adrc_pkg::S_Y1_RND;
      end
      adrc_pkg::S_Y1_RND: begin
        x_nxt     = SAMPLE_BITS'(r24_w);
        state_nxt = adrc_pkg::S_Y2_MUL;
      end
      adrc_pkg::S_Y2_MUL: begin
        prod_nxt  = prod_w;
        state_nxt = adrc_pkg::S_OUT;
      end
      adrc_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sat_w;
          state_nxt     = adrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = adrc_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall      = (state_r != adrc_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_audio_out = out_data_r;

  // assertions
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= adrc_pkg::ONE_Q24)
    else $error("applied gain above unity");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == adrc_pkg::S_DIV1 || state_r == adrc_pkg::S_DIV2) |-> rem_r < dvs_r)
    else $error("divider remainder not below divisor");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while busy");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == adrc_pkg::S_OUT))
    else $error("output loaded outside of the output step");

endmodule

`default_nettype wire

// ----- tb/audio_dynamic_range_compressor_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor_unit_test
// Self-checking bench for the compressor. A directed table covers silence,
// full-scale samples, saturating makeup and knobs past their range. It is
// followed by random phases with fresh knobs and loud or quiet material.
// Each item is scored against a bit-exact model of the envelope follower
// and gain smoother, or a row's fixed value; random gaps on both channels.
// ----------------------------------------------------------------------------
module audio_dynamic_range_compressor_unit_test;

  localparam logic [adrc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam longint UNITY        = 64'sd16777216;
  localparam longint LEVEL_MAX    = 64'sd16777215;
  localparam longint COEF_ATTACK  = 64'sd335544;
  localparam longint COEF_RELEASE = 64'sd25166;
  localparam longint OUT_MAX      = 64'sd8388607;
  localparam longint OUT_MIN      = -64'sd8388608;

  localparam int DIR_ROWS       = 31;
  localparam int N_PHASES       = 10;
  localparam int PHASE_ITEMS    = 143;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [adrc_pkg::CFG_IDX_W-1:0]     idx;
    logic [adrc_pkg::KNOB_W-1:0]        knob;
    logic signed [23:0]                 sample;
    logic                               fixed;
    logic signed [23:0]                 want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_audio_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_audio_out;
  logic cfg_we = 1'b0;
  logic [adrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [adrc_pkg::KNOB_W-1:0] cfg_wdata = '0;

  // model state
  logic [adrc_pkg::KNOB_W-1:0] thr_knob = '0;
  logic [adrc_pkg::KNOB_W-1:0] ratio_knob = '0;
  logic [adrc_pkg::KNOB_W-1:0] makeup_knob = '0;
  longint env_q24 = 0;
  longint gain_q24 = UNITY;

  logic signed [23:0] pending_audio [$];
  logic signed [23:0] head_audio;
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stall_free = 1'b0;
  bit gaps_on;
  int lo_sh;
  int hi_sh;

  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h000000, 1'b1, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h7FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h800000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h000001, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'hFFFFFF, 1'b0, 24'h000000},
    '{ROW_WRITE,  adrc_pkg::CFG_MAKEUP,    7'd100, 24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h800000, 1'b1, 24'h800000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h000000, 1'b1, 24'h000000},
    '{ROW_WRITE,  adrc_pkg::CFG_MAKEUP,    7'd127, 24'h000000, 1'b0, 24'h000000},
    '{ROW_WRITE,  adrc_pkg::CFG_THRESHOLD, 7'd100, 24'h000000, 1'b0, 24'h000000},
    '{ROW_WRITE,  adrc_pkg::CFG_RATIO,     7'd100, 24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h800000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h7FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h800000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h7FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h800000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h7FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h800000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h7FFFFF, 1'b0, 24'h000000},
    '{ROW_WRITE,  adrc_pkg::CFG_THRESHOLD, 7'd127, 24'h000000, 1'b0, 24'h000000},
    '{ROW_WRITE,  adrc_pkg::CFG_RATIO,     7'd127, 24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h000003, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'hFFFFFE, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h000000, 1'b0, 24'h000000},
    '{ROW_WRITE,  CFG_SPARE,               7'd55,  24'h000000, 1'b0, 24'h000000},
    '{ROW_WRITE,  adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h000000, 1'b0, 24'h000000},
    '{ROW_WRITE,  adrc_pkg::CFG_RATIO,     7'd50,  24'h000000, 1'b0, 24'h000000},
    '{ROW_WRITE,  adrc_pkg::CFG_MAKEUP,    7'd0,   24'h000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h7FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, adrc_pkg::CFG_THRESHOLD, 7'd0,   24'h800000, 1'b0, 24'h000000}
  };

  audio_dynamic_range_compressor_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_audio_in   (in_audio_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_audio_out (out_audio_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic longint knob_eff(input logic [adrc_pkg::KNOB_W-1:0] k);
    return (k > 7'd100) ? 64'sd100 : longint'(k);
  endfunction

  function automatic longint follow(input longint cur, input longint goal,
                                    input longint coef);
    return cur + ((coef * (goal - cur) + 64'sd8388608) >>> 24);
  endfunction

  function automatic logic signed [23:0] compress_sample(input logic signed [23:0] s);
    longint x, lvl, thr, den, comp, goal, mk, y1, y;
    x = s;
    lvl = (x < 0) ? -2 * x : 2 * x;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    env_q24 = follow(env_q24, lvl, (lvl > env_q24) ? COEF_ATTACK : COEF_RELEASE);
    if (env_q24 < 0) env_q24 = 0;
    if (env_q24 > LEVEL_MAX) env_q24 = LEVEL_MAX;
    thr = ((3500 - 29 * knob_eff(thr_knob)) * UNITY + 5000) / 10000;
    goal = UNITY;
    if (env_q24 > thr) begin
      den = 50 + 2 * knob_eff(ratio_knob);
      comp = thr + ((env_q24 - thr) * 25 + den / 2) / den;
      goal = (comp * UNITY + env_q24 / 2) / env_q24;
      if (goal > UNITY) goal = UNITY;
    end
    gain_q24 = follow(gain_q24, goal, (goal < gain_q24) ? COEF_ATTACK : COEF_RELEASE);
    if (gain_q24 < 0) gain_q24 = 0;
    if (gain_q24 > UNITY) gain_q24 = UNITY;
    mk = ((900 + 26 * knob_eff(makeup_knob)) * 64'sd4194304 + 500) / 1000;
    y1 = (x * gain_q24 + 64'sd8388608) >>> 24;
    y = (y1 * mk + 64'sd2097152) >>> 22;
    if (y > OUT_MAX) y = OUT_MAX;
    if (y < OUT_MIN) y = OUT_MIN;
    return y[23:0];
  endfunction

  // mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [adrc_pkg::KNOB_W-1:0] pick_knob();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'($urandom_range(101, 127));
      default: return 7'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic logic signed [23:0] pick_sample();
    logic signed [23:0] s;
    case ($urandom_range(0, 31))
      0: s = 24'h7FFFFF;
      1: s = 24'h800000;
      2: s = 24'h000000;
      default: begin
        s = 24'($urandom);
        s = s >>> $urandom_range(lo_sh, hi_sh);
      end
    endcase
    return s;
  endfunction

  task automatic write_knob(input logic [adrc_pkg::CFG_IDX_W-1:0] idx,
                            input logic [adrc_pkg::KNOB_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      adrc_pkg::CFG_THRESHOLD: thr_knob = v;
      adrc_pkg::CFG_RATIO:     ratio_knob = v;
      adrc_pkg::CFG_MAKEUP:    makeup_knob = v;
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic signed [23:0] s, input logic fixed,
                             input logic signed [23:0] fixed_val, input bit with_gaps);
    logic signed [23:0] want;
    int gap;
    cfg_we <= 1'b0;
    in_valid <= 1'b1;
    in_audio_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = compress_sample(s);
    pending_audio.push_back(fixed ? fixed_val : want);
    gap = with_gaps ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_audio.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n || stall_free) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_audio.size() == 0) begin
        $display("%0t: unexpected audio_out item, expected none, actual %0d",
                 $time, out_audio_out);
        mismatches++;
      end else begin
        head_audio = pending_audio.pop_front();
        if (out_audio_out !== head_audio) begin
          $display("%0t: audio_out mismatch, expected %0d, actual %0d",
                   $time, head_audio, out_audio_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d items outstanding",
                 $time, pending_audio.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        if (r > 0 && dir_rows[r-1].kind == ROW_SAMPLE) wait_idle();
        write_knob(dir_rows[r].idx, dir_rows[r].knob);
      end else
        send_sample(dir_rows[r].sample, dir_rows[r].fixed, dir_rows[r].want, 1'b1);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_knob(adrc_pkg::CFG_THRESHOLD, pick_knob());
      write_knob(adrc_pkg::CFG_RATIO, pick_knob());
      write_knob(adrc_pkg::CFG_MAKEUP, pick_knob());
      if ($urandom_range(0, 3) == 0) write_knob(CFG_SPARE, 7'($urandom));
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_free = ($urandom_range(0, 3) == 0);
      // about half the phases stay loud so the gain computer is pushed hard
      lo_sh = $urandom_range(0, 3);
      if ($urandom_range(0, 1) == 0) hi_sh = lo_sh + $urandom_range(0, 2);
      else hi_sh = $urandom_range(lo_sh, 20);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample(pick_sample(), 1'b0, 24'h000000, gaps_on);
    end

    in_valid <= 1'b0;
    while (pending_audio.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
